>>> hdl/tsfpd_pkg.sv
// ----------------------------------------------------------------------------
// tsfpd_pkg
// Shared types and constants of the superframe phase decoder: field widths,
// register map, phase codes and the packed layouts of the stream items.
// ----------------------------------------------------------------------------
package tsfpd_pkg;

   // field widths
   localparam int TIME_W    = 64;
   localparam int WORD_W    = 32;
   localparam int SLOT_W    = 8;
   localparam int PHASE_W   = 3;
   localparam int REQ_W     = 64;
   localparam int RSP_W     = 72;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;

   // one dividend bit per stage
   localparam int DIV_STAGES = TIME_W;

   // slot number that marks a node as not joined
   localparam logic [SLOT_W-1:0] NOT_JOINED_SLOT = 8'hFF;

   // superframe phases
   typedef enum logic [PHASE_W-1:0] {
      PHASE_BEACON     = 3'd0,
      PHASE_CONTENTION = 3'd1,
      PHASE_DATA       = 3'd2,
      PHASE_EMERGENCY  = 3'd3,
      PHASE_IDLE       = 3'd4
   } phase_type;

   // register map, word index
   typedef enum logic [2:0] {
      REG_SUPERFRAME_PERIOD = 3'd0,
      REG_BEACON_LENGTH     = 3'd1,
      REG_CONTENTION_LENGTH = 3'd2,
      REG_EMERGENCY_LENGTH  = 3'd3,
      REG_DATA_SLOT_LENGTH  = 3'd4,
      REG_GUARD_LENGTH      = 3'd5,
      REG_SLOT_COUNT        = 3'd6,
      REG_NODE_SLOT         = 3'd7
   } reg_index_type;

   // reset values
   localparam logic [WORD_W-1:0] RST_SUPERFRAME_PERIOD = 32'd1000000;
   localparam logic [WORD_W-1:0] RST_BEACON_LENGTH     = 32'd10000;
   localparam logic [WORD_W-1:0] RST_CONTENTION_LENGTH = 32'd50000;
   localparam logic [WORD_W-1:0] RST_EMERGENCY_LENGTH  = 32'd50000;
   localparam logic [WORD_W-1:0] RST_DATA_SLOT_LENGTH  = 32'd20000;
   localparam logic [WORD_W-1:0] RST_GUARD_LENGTH      = 32'd1000;
   localparam logic [SLOT_W-1:0] RST_SLOT_COUNT        = 8'd32;
   localparam logic [SLOT_W-1:0] RST_NODE_SLOT         = 8'd255;

   // result item, highest field first
   typedef struct packed {
      logic [3:0]        pad;
      logic [WORD_W-1:0] until_next_slot;
      logic [WORD_W-1:0] slot_remaining;
      logic              in_node_slot;
      phase_type         phase;
   } rsp_item_type;

   // compare results of the offset against the frame boundaries
   typedef struct packed {
      logic lt_beacon;
      logic lt_cont_end;
      logic ge_slots_base;
      logic lt_slots_top;
      logic ge_emg_start;
      logic lt_emg_end;
      logic ge_slot_start;
      logic lt_window_end;
      logic lt_rem_end;
   } cmp_type;

endpackage

>>> hdl/tdma_superframe_phase_decoder_unit.sv
// ----------------------------------------------------------------------------
// tdma_superframe_phase_decoder_unit
// Reduces a 64-bit network time modulo the superframe period and decodes the
// phase and this node's data window timing from the resulting offset.
// ----------------------------------------------------------------------------
// Usage
// - req_ channel: one item is a 64-bit network time in microseconds.
// - rsp_ channel: one item per request: phase, own-window flag, time left in
//   the own window and time until the own window next starts.
// - csr_ port: APB-style registers for the frame layout; write them only while
//   no items are in flight. The derived boundaries settle through registered
//   sum and product levels after a write.
// - Throughput: one item per cycle while the receiver does not stall. A result
//   passes the 64-stage restoring remainder pipeline (one dividend bit per stage,
//   the first stage loading at the accepting edge), then a compare stage and the
//   output register before it shows on rsp_.
// - Reset empties the pipeline and loads the register defaults.
// - When the receiver stalls the whole pipeline holds: req_tready follows
//   rsp_tready while a result is waiting, and no item is lost or repeated.
// ----------------------------------------------------------------------------
module tdma_superframe_phase_decoder_unit (
   input  logic                          clock,
   input  logic                          reset,
   // input stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tsfpd_pkg::REQ_W-1:0]   req_tdata,  // [63:0] network_time
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [2:0] phase, [3] in_node_slot, [35:4] slot_remaining,
   // [67:36] until_next_slot, [71:68] zero
   output logic [tsfpd_pkg::RSP_W-1:0]   rsp_tdata,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tsfpd_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [tsfpd_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [tsfpd_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                          csr_pready
);
   import tsfpd_pkg::*;

   // configuration registers
   logic [WORD_W-1:0] period_ff, beacon_ff, contention_ff, emergency_ff;
   logic [WORD_W-1:0] dsl_ff, guard_ff;
   logic [SLOT_W-1:0] slot_count_ff, node_slot_ff;

   // derived boundaries
   logic [WORD_W-1:0] cont_end_ff, slots_base_ff, slot_len_ff;
   logic [WORD_W-1:0] cnt_prod_ff, node_prod_ff;
   logic [WORD_W-1:0] slots_top_ff, own_base_ff, rem_end_ff;
   logic [WORD_W-1:0] emg_start_ff, emg_end_ff, window_end_ff, wrap_base_ff;
   logic              joined_ff;

   // remainder pipeline
   logic [WORD_W-1:0] rem_ff [0:DIV_STAGES-1];
   logic [WORD_W-1:0] rem_in [0:DIV_STAGES-1];
   logic [TIME_W-1:0] num_ff [0:DIV_STAGES-1];
   logic [TIME_W-1:0] num_in [0:DIV_STAGES-1];
   logic              vld_ff [0:DIV_STAGES-1];

   // compare stage
   logic              mid_vld_ff;
   cmp_type           cmp_ff, cmp_in;
   logic [WORD_W-1:0] rem_diff_ff, next_diff_ff, wrap_diff_ff;
   logic [WORD_W-1:0] t_off;

   // output register
   logic              out_vld_ff;
   rsp_item_type      out_ff, out_in;

   logic              adv;
   logic              csr_wr;
   reg_index_type     csr_idx;
   logic [WORD_W+SLOT_W-1:0] cnt_prod_full, node_prod_full;

   // pipeline moves when the output register is free or being emptied
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= RST_SUPERFRAME_PERIOD;
         beacon_ff     <= RST_BEACON_LENGTH;
         contention_ff <= RST_CONTENTION_LENGTH;
         emergency_ff  <= RST_EMERGENCY_LENGTH;
         dsl_ff        <= RST_DATA_SLOT_LENGTH;
         guard_ff      <= RST_GUARD_LENGTH;
         slot_count_ff <= RST_SLOT_COUNT;
         node_slot_ff  <= RST_NODE_SLOT;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_SUPERFRAME_PERIOD: period_ff     <= csr_pwdata;
            REG_BEACON_LENGTH:     beacon_ff     <= csr_pwdata;
            REG_CONTENTION_LENGTH: contention_ff <= csr_pwdata;
            REG_EMERGENCY_LENGTH:  emergency_ff  <= csr_pwdata;
            REG_DATA_SLOT_LENGTH:  dsl_ff        <= csr_pwdata;
            REG_GUARD_LENGTH:      guard_ff      <= csr_pwdata;
            REG_SLOT_COUNT:        slot_count_ff <= csr_pwdata[SLOT_W-1:0];
            REG_NODE_SLOT:         node_slot_ff  <= csr_pwdata[SLOT_W-1:0];
            default: ;
         endcase
      end
   end

   // register read-back
   always_comb begin
      case (csr_idx)
         REG_SUPERFRAME_PERIOD: csr_prdata = period_ff;
         REG_BEACON_LENGTH:     csr_prdata = beacon_ff;
         REG_CONTENTION_LENGTH: csr_prdata = contention_ff;
         REG_EMERGENCY_LENGTH:  csr_prdata = emergency_ff;
         REG_DATA_SLOT_LENGTH:  csr_prdata = dsl_ff;
         REG_GUARD_LENGTH:      csr_prdata = guard_ff;
         REG_SLOT_COUNT:        csr_prdata = {{(CSR_DW-SLOT_W){1'b0}}, slot_count_ff};
         REG_NODE_SLOT:         csr_prdata = {{(CSR_DW-SLOT_W){1'b0}}, node_slot_ff};
         default:               csr_prdata = '0;
      endcase
   end

   // frame boundaries, all sums wrap at 32 bits
   assign cnt_prod_full  = slot_len_ff * slot_count_ff;
   assign node_prod_full = slot_len_ff * node_slot_ff;

   always_ff @(posedge clock) begin
      // first level: plain sums of registers and the joined flag
      cont_end_ff    <= beacon_ff + contention_ff;
      slots_base_ff  <= beacon_ff + contention_ff + guard_ff;
      slot_len_ff    <= dsl_ff + guard_ff;
      joined_ff      <= (node_slot_ff != NOT_JOINED_SLOT) && (node_slot_ff < slot_count_ff);
      // second level: slot products
      cnt_prod_ff    <= cnt_prod_full[WORD_W-1:0];
      node_prod_ff   <= node_prod_full[WORD_W-1:0];
      // third level: region and own slot edges
      slots_top_ff   <= slots_base_ff + cnt_prod_ff;
      own_base_ff    <= slots_base_ff + node_prod_ff;
      rem_end_ff     <= slots_base_ff + node_prod_ff + slot_len_ff - guard_ff;
      // fourth level
      emg_start_ff   <= slots_top_ff + guard_ff;
      emg_end_ff     <= slots_top_ff + guard_ff + emergency_ff;
      window_end_ff  <= own_base_ff + dsl_ff;
      wrap_base_ff   <= period_ff + own_base_ff;
   end

   // restoring remainder, one dividend bit per stage; a zero period leaves
   // the last 32 dividend bits, which is the low word of the time
   always_comb begin
      logic [WORD_W-1:0] src_rem;
      logic [TIME_W-1:0] src_num;
      logic [WORD_W:0]   trial;
      logic [WORD_W+1:0] diff;
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            src_rem = '0;
            src_num = req_tdata;
         end else begin
            src_rem = rem_ff[k-1];
            src_num = num_ff[k-1];
         end
         trial = {src_rem, src_num[TIME_W-1]};
         diff  = {1'b0, trial} - {2'b00, period_ff};
         if (diff[WORD_W+1]) begin
            rem_in[k] = trial[WORD_W-1:0];
         end else begin
            rem_in[k] = diff[WORD_W-1:0];
         end
         num_in[k] = {src_num[TIME_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < DIV_STAGES; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            num_ff[k] <= num_in[k];
         end
      end
   end

   // compare the offset with every boundary
   assign t_off = rem_ff[DIV_STAGES-1];

   always_comb begin
      cmp_in.lt_beacon     = t_off < beacon_ff;
      cmp_in.lt_cont_end   = t_off < cont_end_ff;
      cmp_in.ge_slots_base = t_off >= slots_base_ff;
      cmp_in.lt_slots_top  = t_off < slots_top_ff;
      cmp_in.ge_emg_start  = t_off >= emg_start_ff;
      cmp_in.lt_emg_end    = t_off < emg_end_ff;
      cmp_in.ge_slot_start = t_off >= own_base_ff;
      cmp_in.lt_window_end = t_off < window_end_ff;
      cmp_in.lt_rem_end    = t_off < rem_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_vld_ff <= 1'b0;
      end else if (adv) begin
         mid_vld_ff <= vld_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmp_ff       <= cmp_in;
         rem_diff_ff  <= rem_end_ff - t_off;
         next_diff_ff <= own_base_ff - t_off;
         wrap_diff_ff <= wrap_base_ff - t_off;
      end
   end

   // phase priority and result selection
   always_comb begin
      out_in     = '0;
      if (cmp_ff.lt_beacon) begin
         out_in.phase = PHASE_BEACON;
      end else if (cmp_ff.lt_cont_end) begin
         out_in.phase = PHASE_CONTENTION;
      end else if (cmp_ff.ge_slots_base && cmp_ff.lt_slots_top) begin
         out_in.phase = PHASE_DATA;
      end else if (cmp_ff.ge_emg_start && cmp_ff.lt_emg_end) begin
         out_in.phase = PHASE_EMERGENCY;
      end else begin
         out_in.phase = PHASE_IDLE;
      end
      out_in.in_node_slot = joined_ff && cmp_ff.ge_slot_start && cmp_ff.lt_window_end;
      out_in.slot_remaining = cmp_ff.lt_rem_end ? rem_diff_ff : '0;
      if (!joined_ff) begin
         out_in.until_next_slot = period_ff;
      end else if (!cmp_ff.ge_slot_start) begin
         out_in.until_next_slot = next_diff_ff;
      end else begin
         out_in.until_next_slot = wrap_diff_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= mid_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

endmodule
